// ===== rtl/core/ovl_pkg.sv =====
// Shared types and constants for the ordered value list.
package ovl_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int CMD_W = 3;
  localparam int STS_W = 2;
  localparam int POS_W = 4;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL     = 2'd2;
  localparam logic [STS_W-1:0] STS_EMPTY    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_EXEC,
    ST_RESP
  } ovl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic find;
    logic exec;
    logic step;
  } ovl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_valid;
    logic last;
  } ovl_sts_t;

endpackage

// ===== rtl/core/ovl_ctrl.sv =====
// Sequencing state machine for the ordered value list.
module ovl_ctrl import ovl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ovl_sts_t sts,
  output ovl_cmd_t ctl
);

  ovl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_FIND;
      end
      ST_FIND: state_next = ST_EXEC;
      ST_EXEC: begin
        state_next = sts.op_valid ? ST_RESP : ST_IDLE;
      end
      ST_RESP: begin
        if (out_ready && sts.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ctl         = '0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_FIND: ctl.find = 1'b1;
      ST_EXEC: ctl.exec = 1'b1;
      ST_RESP: begin
        out_valid = 1'b1;
        ctl.step  = out_ready && !sts.last;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/ovl_dp.sv =====
// Entry cells, match logic, fill count and result register.
module ovl_dp import ovl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  ovl_cmd_t                ctl,
  output ovl_sts_t                sts,
  input  logic [CMD_W-1:0]        cmd,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] new_value,
  output logic [STS_W-1:0]        status,
  output logic signed [VAL_W-1:0] item_value,
  output logic [POS_W-1:0]        position,
  output logic                    last_item
);

  logic signed [VAL_W-1:0] entries [DEPTH];
  logic [CNT_W-1:0]        count;
  logic [CMD_W-1:0]        op;
  logic signed [VAL_W-1:0] key;
  logic signed [VAL_W-1:0] repl;
  logic                    found;
  logic [IDX_W-1:0]        match_idx;
  logic [IDX_W-1:0]        rd_idx;
  logic                    full;

  logic                    hit_any;
  logic [IDX_W-1:0]        hit_idx;

  assign full = (count >= CNT_W'(DEPTH));

  // first equal entry below the fill count; scan from top so lowest wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < count) && (entries[i] == key)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op   <= cmd;
      key  <= value;
      repl <= new_value;
    end
    if (ctl.find) begin
      found     <= hit_any;
      match_idx <= hit_idx;
    end
  end

  // cell writes: append at tail, close up on delete, overwrite on replace
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        case (op)
          CMD_APPEND: begin
            if (!full && (CNT_W'(i) == count)) entries[i] <= key;
          end
          CMD_DELETE: begin
            if (found && (IDX_W'(i) >= match_idx) && (i < DEPTH - 1))
              entries[i] <= entries[(i + 1) % DEPTH];
          end
          CMD_REPLACE: begin
            if (found && (IDX_W'(i) == match_idx)) entries[i] <= repl;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.exec) begin
      case (op)
        CMD_APPEND: begin
          if (!full) count <= count + 1'b1;
        end
        CMD_DELETE: begin
          if (found) count <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status     <= STS_NOTFOUND;
      item_value <= '0;
      position   <= '0;
      last_item  <= 1'b1;
      rd_idx     <= IDX_W'(1);
      case (op)
        CMD_APPEND: begin
          if (full) begin
            status <= STS_FULL;
          end else begin
            status     <= STS_OK;
            item_value <= key;
            position   <= POS_W'(count[IDX_W-1:0]);
          end
        end
        CMD_DELETE, CMD_SEARCH: begin
          if (found) begin
            status     <= STS_OK;
            item_value <= key;
            position   <= POS_W'(match_idx);
          end
        end
        CMD_REPLACE: begin
          if (found) begin
            status     <= STS_OK;
            item_value <= repl;
            position   <= POS_W'(match_idx);
          end
        end
        CMD_READ: begin
          if (count == '0) begin
            status <= STS_EMPTY;
          end else begin
            status     <= STS_OK;
            item_value <= entries[0];
            last_item  <= (count == CNT_W'(1));
          end
        end
        default: ;
      endcase
    end else if (ctl.step) begin
      item_value <= entries[rd_idx];
      position   <= POS_W'(rd_idx);
      last_item  <= ((CNT_W'(rd_idx) + 1'b1) == count);
      rd_idx     <= rd_idx + 1'b1;
    end
  end

  assign sts.op_valid = (op <= CMD_READ);
  assign sts.last     = last_item;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && op == CMD_APPEND && !full) |=> (count == $past(count) + 1'b1))
    else $error("append did not grow the list");

  a_step_ok: assert property (@(posedge clk) disable iff (rst)
    ctl.step |=> (status == STS_OK))
    else $error("read-out beat without ok status");

endmodule

// ===== rtl/core/ordered_value_list_core.sv =====
// Ordered value list: top level joining controller and datapath.
// Sequence: an accepted input beat passes through the find and exec states; its first
//   result beat is then shown from the result register in the resp state.
// Read-out gives one further entry per cycle while out_ready is high. A new command is
//   taken only after the previous one's last result beat; op codes above CMD_READ have none.
// Reset (rst, synchronous): controller to idle and fill count to zero; cell contents kept.
module ordered_value_list_core import ovl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        cmd,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] new_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STS_W-1:0]        status,
  output logic signed [VAL_W-1:0] item_value,
  output logic [POS_W-1:0]        position,
  output logic                    last_item
);

  ovl_cmd_t ctl;
  ovl_sts_t sts;

  // state machine: idle / find (broadcast compare) / exec (write, shift) / resp
  ovl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // cells, match encoder, fill count, result register
  ovl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (cmd),
    .value      (value),
    .new_value  (new_value),
    .status     (status),
    .item_value (item_value),
    .position   (position),
    .last_item  (last_item)
  );

  // one command in flight: never ready for input while a result beat is shown
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // an empty read-out is a single beat
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STS_EMPTY) |-> last_item)
    else $error("empty status without last marker");

  // after the last beat is taken the block is free again
  a_free_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_item) |=> in_ready)
    else $error("not idle after final beat");

endmodule
